// ===== design/hex_escape_decoder_unit_defines.svh =====
// Assertion macros shared by the hex escape decoder modules.
`ifndef HEX_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define HEX_ESCAPE_DECODER_UNIT_DEFINES_SVH

// Checks a property at every rising edge of clk outside of reset.
`define HED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define HED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hed_pkg.sv =====
// Shared constants, types and helper functions of the hex escape decoder.
package hed_pkg;

  // Character codes that the decoder looks for.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_UPPER_X   = 8'h58;

  // One input character causes at most this many result bytes.
  localparam int MAX_EMIT = 4;
  localparam int EMIT_CW  = $clog2(MAX_EMIT + 1);
  localparam int EMIT_IW  = $clog2(MAX_EMIT);

  // Result buffer geometry.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result byte with its end-of-string mark.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } hed_entry_t;

  // The group of result bytes that one accepted character produces.
  typedef struct packed {
    hed_entry_t [MAX_EMIT-1:0] entry;
    logic [EMIT_CW-1:0]        count;
  } hed_emit_t;

  // Decodes a hex digit of either case; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, 4'(ch - 8'h37)};
    end
    return res;
  endfunction

endpackage

// ===== design/hed_decode.sv =====
// Escape sequence tracker: holds partial escapes and builds the result bytes per character.
`include "hex_escape_decoder_unit_defines.svh"

module hed_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc_i,
  input  logic [7:0]         in_char_i,
  input  logic               is_final_i,
  output hed_pkg::hed_emit_t emit_o
);

  // Sequence progress codes.
  localparam logic [1:0] STAGE_IDLE = 2'd0;
  localparam logic [1:0] STAGE_BS   = 2'd1;
  localparam logic [1:0] STAGE_X    = 2'd2;
  localparam logic [1:0] STAGE_DIG  = 2'd3;
  localparam int         NUM_CAND   = 7;

  logic [1:0] stage_r, stage_nxt;
  logic [7:0] held_x_r, held_x_nxt;
  logic [7:0] held_digit_r, held_digit_nxt;

  logic       is_x;
  logic [4:0] hex_ch;
  logic [4:0] hex_hd;
  logic       brk;
  logic       fresh;
  logic       mid_en;
  logic [7:0] mid_byte;
  logic [1:0] stage_mid;
  logic [1:0] old_flush;
  logic [1:0] new_flush;
  logic [NUM_CAND-1:0]      cand_en;
  logic [NUM_CAND-1:0][7:0] cand_byte;
  logic [hed_pkg::EMIT_CW-1:0] idx;
  hed_pkg::hed_emit_t emit;

  // Classify the character against the current stage.
  always_comb begin
    is_x           = (in_char_i == hed_pkg::CH_LOWER_X) || (in_char_i == hed_pkg::CH_UPPER_X);
    hex_ch         = hed_pkg::hex_digit(in_char_i);
    hex_hd         = hed_pkg::hex_digit(held_digit_r);
    brk            = 1'b0;
    fresh          = 1'b0;
    mid_en         = 1'b0;
    mid_byte       = in_char_i;
    stage_mid      = stage_r;
    held_x_nxt     = held_x_r;
    held_digit_nxt = held_digit_r;
    unique case (stage_r)
      STAGE_IDLE: begin
        fresh = 1'b1;
      end
      STAGE_BS: begin
        if (is_x) begin
          stage_mid  = STAGE_X;
          held_x_nxt = in_char_i;
        end else begin
          brk   = 1'b1;
          fresh = 1'b1;
        end
      end
      STAGE_X: begin
        if (hex_ch[4]) begin
          stage_mid      = STAGE_DIG;
          held_digit_nxt = in_char_i;
        end else begin
          brk   = 1'b1;
          fresh = 1'b1;
        end
      end
      STAGE_DIG: begin
        if (hex_ch[4]) begin
          stage_mid = STAGE_IDLE;
          mid_en    = 1'b1;
          mid_byte  = {hex_hd[3:0], hex_ch[3:0]};
        end else begin
          brk   = 1'b1;
          fresh = 1'b1;
        end
      end
      default: begin
        stage_mid = STAGE_IDLE;
      end
    endcase
    // A character handled afresh either opens an escape or passes through.
    if (fresh) begin
      if (in_char_i == hed_pkg::CH_BACKSLASH) begin
        stage_mid = STAGE_BS;
      end else begin
        stage_mid = STAGE_IDLE;
        mid_en    = 1'b1;
      end
    end
    old_flush = brk ? stage_r : STAGE_IDLE;
    new_flush = is_final_i ? stage_mid : STAGE_IDLE;
    stage_nxt = is_final_i ? STAGE_IDLE : stage_mid;
  end

  // Candidate bytes in output order: old held flush, middle byte, final flush.
  always_comb begin
    cand_en[0]   = (old_flush >= STAGE_BS);
    cand_byte[0] = hed_pkg::CH_BACKSLASH;
    cand_en[1]   = (old_flush >= STAGE_X);
    cand_byte[1] = held_x_r;
    cand_en[2]   = (old_flush >= STAGE_DIG);
    cand_byte[2] = held_digit_r;
    cand_en[3]   = mid_en;
    cand_byte[3] = mid_byte;
    cand_en[4]   = (new_flush >= STAGE_BS);
    cand_byte[4] = hed_pkg::CH_BACKSLASH;
    cand_en[5]   = (new_flush >= STAGE_X);
    cand_byte[5] = held_x_nxt;
    cand_en[6]   = (new_flush >= STAGE_DIG);
    cand_byte[6] = held_digit_nxt;
  end

  // Pack the enabled candidates into consecutive slots and mark the last one.
  always_comb begin
    emit = '0;
    idx  = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_en[i] && (idx < hed_pkg::EMIT_CW'(hed_pkg::MAX_EMIT))) begin
        emit.entry[idx[hed_pkg::EMIT_IW-1:0]].data = cand_byte[i];
        idx = idx + hed_pkg::EMIT_CW'(1);
      end
    end
    for (int j = 0; j < hed_pkg::MAX_EMIT; j++) begin
      emit.entry[j].last = is_final_i && (hed_pkg::EMIT_CW'(j + 1) == idx);
    end
    emit.count = idx;
  end

  assign emit_o = emit;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= STAGE_IDLE;
    end else if (acc_i) begin
      stage_r <= stage_nxt;
    end
  end

  // Held characters of a started escape.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r     <= 8'h00;
      held_digit_r <= 8'h00;
    end else if (acc_i) begin
      held_x_r     <= held_x_nxt;
      held_digit_r <= held_digit_nxt;
    end
  end

  `HED_ASSERT_NEXT(final_clears_stage_a, acc_i && is_final_i, stage_r == STAGE_IDLE,
    "final character left a partial escape held")
  `HED_ASSERT(final_emits_a, !(acc_i && is_final_i) || (emit.count != '0),
    "final character produced no result")

endmodule

// ===== design/hed_fifo.sv =====
// Result buffer: takes up to four bytes per cycle and hands them out one per cycle while the output is taken.
`include "hex_escape_decoder_unit_defines.svh"

module hed_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  hed_pkg::hed_emit_t emit_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hed_pkg::hed_entry_t out_entry_o
);

  hed_pkg::hed_entry_t mem [hed_pkg::FIFO_DEPTH];

  logic [hed_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hed_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hed_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [hed_pkg::EMIT_CW-1:0] wr_n;
  logic                        pop;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_n       = push_i ? emit_i.count : '0;
    pop        = out_valid_o && out_ready_i;
    wr_ptr_nxt = wr_ptr_r + hed_pkg::FIFO_AW'(wr_n);
    rd_ptr_nxt = rd_ptr_r + hed_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + hed_pkg::FIFO_CW'(wr_n) - hed_pkg::FIFO_CW'(pop);
  end

  assign room_o      = (count_r <= hed_pkg::FIFO_CW'(hed_pkg::FIFO_DEPTH - hed_pkg::MAX_EMIT));
  assign out_valid_o = (count_r != '0);
  assign out_entry_o = mem[rd_ptr_r];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the new bytes into consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < hed_pkg::MAX_EMIT; i++) begin
      if (hed_pkg::EMIT_CW'(i) < wr_n) begin
        mem[wr_ptr_r + hed_pkg::FIFO_AW'(i)] <= emit_i.entry[i];
      end
    end
  end

  `HED_ASSERT(count_bound_a, count_r <= hed_pkg::FIFO_CW'(hed_pkg::FIFO_DEPTH),
    "result buffer overfilled")
  `HED_ASSERT(ptr_count_a, (count_r == hed_pkg::FIFO_CW'(hed_pkg::FIFO_DEPTH)) ||
    (hed_pkg::FIFO_AW'(wr_ptr_r - rd_ptr_r) == count_r[hed_pkg::FIFO_AW-1:0]),
    "buffer pointers disagree with fill count")

endmodule

// ===== design/hex_escape_decoder_unit.sv =====
// Top level of the hex escape decoder: input handshake, decoder and result buffer.
//
// The block decodes a character stream in which backslash, x or X and two hex
// digits become one byte; every other character passes through, and a broken
// escape comes out as the characters that were held. One character can be
// accepted in every cycle. Its results enter an eight-entry result buffer in
// the same edge and appear at the output from the next cycle on, one byte per
// cycle. A character yields zero to four bytes; the input is ready whenever the
// buffer has four free entries, so with the output always taken the stream
// runs at one character per cycle, and a stalled output stops the input once
// the buffer holds more than four bytes. The last byte of a string carries tlast.
`include "hex_escape_decoder_unit_defines.svh"

module hex_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // end_of_string
);

  logic                room;
  logic                acc;
  hed_pkg::hed_emit_t  emit;
  hed_pkg::hed_entry_t head;

  // A request is taken when the buffer can absorb its worst-case results.
  assign in_tready = room;
  assign acc       = in_tvalid && room;

  hed_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (acc),
    .in_char_i  (in_tdata),
    .is_final_i (in_tlast),
    .emit_o     (emit)
  );

  hed_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (acc),
    .emit_i      (emit),
    .room_o      (room),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_entry_o (head)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the hex escape decoder unit.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // Progress of the escape sequence held by the predictor.
  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_BSLASH,
    ESC_X,
    ESC_DIGIT
  } esc_stage_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_char
  logic       in_tlast = 1'b0;    // is_final
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;          // end_of_string

  // Predictor state and the bytes still owed by the block.
  esc_stage_t esc_stage = ESC_NONE;
  logic [7:0] held_x = 8'h00;
  logic [7:0] held_digit = 8'h00;
  hed_pkg::hed_entry_t expected_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int chars_sent = 0;
  int strings_ended = 0;
  int bytes_checked = 0;

  hex_escape_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Value of a hex digit of either case, or -1 for any other character.
  function automatic int hex_value(input logic [7:0] ch);
    if (ch inside {[8'h30:8'h39]}) return int'(ch) - 'h30;
    if (ch inside {[8'h61:8'h66]}) return int'(ch) - 'h61 + 10;
    if (ch inside {[8'h41:8'h46]}) return int'(ch) - 'h41 + 10;
    return -1;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    hed_pkg::hed_entry_t e;
    e.data = b;
    e.last = 1'b0;
    expected_bytes.push_back(e);
  endtask

  // Emits the held characters in arrival order and forgets them.
  task automatic flush_held();
    if (esc_stage != ESC_NONE) push_byte(hed_pkg::CH_BACKSLASH);
    if (esc_stage == ESC_X || esc_stage == ESC_DIGIT) push_byte(held_x);
    if (esc_stage == ESC_DIGIT) push_byte(held_digit);
    esc_stage = ESC_NONE;
  endtask

  task automatic take_fresh(input logic [7:0] ch);
    if (ch == hed_pkg::CH_BACKSLASH) esc_stage = ESC_BSLASH;
    else push_byte(ch);
  endtask

  // Works out the result bytes that one accepted character causes.
  task automatic decode_char(input logic [7:0] ch, input logic fin);
    int base;
    int v;
    base = expected_bytes.size();
    v = hex_value(ch);
    case (esc_stage)
      ESC_NONE: begin
        take_fresh(ch);
      end
      ESC_BSLASH: begin
        if (ch == hed_pkg::CH_LOWER_X || ch == hed_pkg::CH_UPPER_X) begin
          held_x = ch;
          esc_stage = ESC_X;
        end else begin
          flush_held();
          take_fresh(ch);
        end
      end
      ESC_X: begin
        if (v >= 0) begin
          held_digit = ch;
          esc_stage = ESC_DIGIT;
        end else begin
          flush_held();
          take_fresh(ch);
        end
      end
      default: begin
        if (v >= 0) begin
          push_byte(8'(hex_value(held_digit) * 16 + v));
          esc_stage = ESC_NONE;
        end else begin
          flush_held();
          take_fresh(ch);
        end
      end
    endcase
    // The end of a string flushes what is held and marks the last byte.
    if (fin) begin
      flush_held();
      if (expected_bytes.size() > base) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Compares every accepted result with the oldest expected byte.
  always @(posedge clk) begin
    hed_pkg::hed_entry_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (out_tdata !== e.data || out_tlast !== e.last) begin
          note_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                  e.data, e.last, out_tdata, out_tlast));
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one character and waits until the block takes the request.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    decode_char(ch, fin);
    chars_sent++;
    if (fin) strings_ended++;
  endtask

  // Lowers the request and waits until every expected byte has come.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic rand_final();
    return ($urandom_range(11) == 0);
  endfunction

  // Mostly complete escapes with random digits, plus plain and broken runs.
  task automatic send_random_run(input int n_items);
    int sent;
    int pick;
    int parts;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_char(hed_pkg::CH_BACKSLASH, rand_final());
        send_char($urandom_range(1) ? hed_pkg::CH_LOWER_X : hed_pkg::CH_UPPER_X, rand_final());
        send_char(rand_hex_char(), rand_final());
        send_char(rand_hex_char(), rand_final());
        sent += 4;
      end else if (pick < 80) begin
        // A started escape cut short by an arbitrary character.
        parts = $urandom_range(2);
        send_char(hed_pkg::CH_BACKSLASH, rand_final());
        if (parts >= 1) begin
          send_char($urandom_range(1) ? hed_pkg::CH_LOWER_X : hed_pkg::CH_UPPER_X,
                    rand_final());
        end
        if (parts >= 2) send_char(rand_hex_char(), rand_final());
        send_char(8'($urandom_range(255)), rand_final());
        sent += parts + 2;
      end else begin
        send_char(8'($urandom_range(255)), rand_final());
        sent++;
      end
    end
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  // Escapes of both cases, breaks at each stage, and strings ending mid-escape.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_LOWER_X, 1'b0);
    send_char("4", 1'b0);
    send_char("1", 1'b0);
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_UPPER_X, 1'b0);
    send_char("f", 1'b0);
    send_char("F", 1'b1);
    // Zero character breaks an escape right after the backslash.
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(8'h00, 1'b0);
    // A non-digit after the first hex digit.
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_LOWER_X, 1'b0);
    send_char("9", 1'b0);
    send_char("g", 1'b0);
    // A backslash breaks one escape and opens the next.
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_LOWER_X, 1'b0);
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_LOWER_X, 1'b0);
    send_char("7", 1'b0);
    send_char("a", 1'b0);
    send_char(8'hFF, 1'b1);
    // Strings that end while an escape is held.
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_UPPER_X, 1'b1);
    send_char(hed_pkg::CH_BACKSLASH, 1'b0);
    send_char(hed_pkg::CH_LOWER_X, 1'b0);
    send_char("A", 1'b1);
    wait_drained();
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    send_random_run(n_items);
    wait_drained();
  endtask

  // The receiver holds off long enough for the result buffer to fill.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_cycles = 60;
    repeat (15) send_char(8'($urandom_range(255)), 1'b0);
    send_char(8'($urandom_range(255)), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(0, 0, 14);
    test_random_phase(57, 0, 14);
    test_random_phase(0, 57, 14);
    test_random_phase(9, 9, 14);
    test_backpressure();

    $display("Sent %0d characters in %0d strings and checked %0d result bytes,", chars_sent,
             strings_ended, bytes_checked);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d expected bytes never arrived", mismatches,
               expected_bytes.size());
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
